[src/tsl_pkg.sv]
// Shared types and constants for the track segment locator.
// Used by tsl_quad_eval and track_segment_locator; depends on nothing.
package tsl_pkg;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int IDX_W   = 8;
  localparam int CNT_W   = 9;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // One cross-section: left and right edge points.
  typedef struct packed {
    logic signed [COORD_W-1:0] ry;
    logic signed [COORD_W-1:0] rx;
    logic signed [COORD_W-1:0] ly;
    logic signed [COORD_W-1:0] lx;
  } entry_t;

  // Quad to test: near cross-section (i) and far cross-section (i+1).
  typedef struct packed {
    logic   valid;
    entry_t near;
    entry_t far;
  } quad_req_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } quad_res_t;

endpackage

[src/tsl_quad_eval.sv]
// Pipelined point-in-quad test: edge/offset differences, cross products, sign check.
// Depends on tsl_pkg. Results come out in request order; differences, then products are registered.
module tsl_quad_eval (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                flush,
  input  tsl_pkg::quad_req_t                  req,
  input  logic signed [tsl_pkg::COORD_W-1:0]  qx,
  input  logic signed [tsl_pkg::COORD_W-1:0]  qy,
  output tsl_pkg::quad_res_t                  res
);

  logic signed [tsl_pkg::COORD_W-1:0] px [4];
  logic signed [tsl_pkg::COORD_W-1:0] py [4];

  logic signed [tsl_pkg::DIFF_W-1:0]  ex [4];
  logic signed [tsl_pkg::DIFF_W-1:0]  ey [4];
  logic signed [tsl_pkg::DIFF_W-1:0]  dx [4];
  logic signed [tsl_pkg::DIFF_W-1:0]  dy [4];
  logic                               s1_valid;

  logic signed [tsl_pkg::PROD_W-1:0]  pa [4];
  logic signed [tsl_pkg::PROD_W-1:0]  pb [4];
  logic                               s2_valid;

  logic signed [tsl_pkg::CROSS_W-1:0] xprod [4];
  logic [3:0]                         pos;
  logic [3:0]                         neg;
  logic                               opposite;

  // Corners in order: left i, right i, right i+1, left i+1.
  always_comb begin
    px[0] = req.near.lx;  py[0] = req.near.ly;
    px[1] = req.near.rx;  py[1] = req.near.ry;
    px[2] = req.far.rx;   py[2] = req.far.ry;
    px[3] = req.far.lx;   py[3] = req.far.ly;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      ex[k] <= tsl_pkg::DIFF_W'(px[(k + 1) % 4]) - tsl_pkg::DIFF_W'(px[k]);
      ey[k] <= tsl_pkg::DIFF_W'(py[(k + 1) % 4]) - tsl_pkg::DIFF_W'(py[k]);
      dx[k] <= tsl_pkg::DIFF_W'(qx) - tsl_pkg::DIFF_W'(px[k]);
      dy[k] <= tsl_pkg::DIFF_W'(qy) - tsl_pkg::DIFF_W'(py[k]);
      pa[k] <= ex[k] * dy[k];
      pb[k] <= ey[k] * dx[k];
    end
    if (rst || flush) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= req.valid;
      s2_valid <= s1_valid;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      xprod[k] = tsl_pkg::CROSS_W'(pa[k]) - tsl_pkg::CROSS_W'(pb[k]);
      neg[k]   = xprod[k][tsl_pkg::CROSS_W-1];
      pos[k]   = !neg[k] && (xprod[k] != '0);
    end
    // A zero product breaks the chain, so only adjacent pairs matter.
    opposite = (pos[0] & neg[1]) | (neg[0] & pos[1]) |
               (pos[1] & neg[2]) | (neg[1] & pos[2]) |
               (pos[2] & neg[3]) | (neg[2] & pos[3]);
    res.valid = s2_valid;
    res.hit   = !opposite;
  end

endmodule

[src/track_segment_locator.sv]
// Track segment locator: table of cross-sections in one synchronous memory,
// point queries tested quad by quad. Depends on tsl_pkg and tsl_quad_eval.
// Flow: a load beat or a query with no quad to test goes from IDLE to RESULT; a query that
//   checks n quads (n up to MAX_CHECKS) runs in RUN first. RESULT raises m_tvalid once out is free.
// Throughput: one item at a time, as s_tready is high only in IDLE. A query reads the table once
//   per cross-section and passes each quad through the compare pipeline.
// Reset clears control, current segment and segment_count; the table is not cleared.
module track_segment_locator #(
  parameter int MAX_SEGMENTS = 256,
  parameter int BACK_STEPS   = 5,
  parameter int MAX_CHECKS   = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [tsl_pkg::CNT_W-1:0] cfg_wdata,  // segment_count
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [103:0]              s_tdata,    // entry_index, left_x, left_y, right_x,
                                                // right_y, query_x, query_y
  input  logic                      s_tuser,    // mode
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata     // found, segment_index, zero fill
);

  localparam int IW = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int WW = ((CW > 7) ? CW : 7) + 2;
  localparam int QW = $clog2(MAX_CHECKS + 2);

  typedef enum logic [1:0] {IDLE, RUN, RESULT} state_t;

  state_t                             state;
  logic [tsl_pkg::CNT_W-1:0]          seg_count;
  logic [IW-1:0]                      cur_seg;
  logic signed [tsl_pkg::COORD_W-1:0] qx;
  logic signed [tsl_pkg::COORD_W-1:0] qy;
  logic [IW-1:0]                      rd_addr;
  logic [QW-1:0]                      issue_left;
  logic [QW-1:0]                      eval_left;
  logic [IW-1:0]                      eval_seg;
  logic                               rd_valid;
  logic                               have_prev;
  tsl_pkg::entry_t                    prev_e;
  tsl_pkg::entry_t                    rdata;
  logic                               res_found;
  logic                               out_found;
  logic [tsl_pkg::IDX_W-1:0]          out_seg;

  tsl_pkg::entry_t                    mem [MAX_SEGMENTS];

  logic                               accept;
  logic                               is_query;
  logic [tsl_pkg::IDX_W-1:0]          entry_index;
  tsl_pkg::entry_t                    w_entry;
  logic signed [WW-1:0]               cur_w;
  logic signed [WW-1:0]               start_w;
  logic signed [WW-1:0]               count_w;
  logic signed [WW-1:0]               span_w;
  logic [QW-1:0]                      nq;
  logic                               issue;
  logic                               fin_hit;
  logic                               fin_miss;
  logic                               finish;
  logic                               out_free;
  tsl_pkg::quad_req_t                 req;
  tsl_pkg::quad_res_t                 res;

  assign s_tready    = (state == IDLE);
  assign accept      = s_tvalid && s_tready;
  assign is_query    = (s_tuser == tsl_pkg::MODE_QUERY);
  assign entry_index = s_tdata[7:0];
  assign w_entry     = '{ry: s_tdata[71:56], rx: s_tdata[55:40],
                         ly: s_tdata[39:24], lx: s_tdata[23:8]};
  assign out_free    = !m_tvalid || m_tready;
  assign m_tdata     = {7'b0, out_seg, out_found};

  // Window of the query: start behind the current segment, stop before the last entry.
  always_comb begin
    cur_w   = WW'(cur_seg);
    start_w = (cur_w > WW'(BACK_STEPS)) ? cur_w - WW'(BACK_STEPS) : '0;
    count_w = (WW'(seg_count) > WW'(MAX_SEGMENTS)) ? WW'(MAX_SEGMENTS) : WW'(seg_count);
    span_w  = count_w - WW'(1) - start_w;
    if (span_w <= 0)
      nq = '0;
    else if (span_w > WW'(MAX_CHECKS))
      nq = QW'(MAX_CHECKS);
    else
      nq = QW'(span_w);
  end

  assign fin_hit  = (state == RUN) && res.valid && res.hit;
  assign fin_miss = (state == RUN) && res.valid && !res.hit && (eval_left == QW'(1));
  assign finish   = fin_hit || fin_miss;
  assign issue    = (state == RUN) && (issue_left != '0) && !finish;

  assign req.valid = (state == RUN) && rd_valid && have_prev;
  assign req.near  = prev_e;
  assign req.far   = rdata;

  // Table memory: one write port for load beats, one registered read port.
  // Loads and queries never overlap, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (accept && !is_query && (int'(entry_index) < MAX_SEGMENTS)) begin
      mem[IW'(entry_index)] <= w_entry;
    end
    if (issue) begin
      rdata <= mem[rd_addr];
    end
  end

  tsl_quad_eval u_eval (
    .clk   (clk),
    .rst   (rst),
    .flush (finish),
    .req   (req),
    .qx    (qx),
    .qy    (qy),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      seg_count <= '0;
      cur_seg   <= '0;
      rd_valid  <= 1'b0;
      have_prev <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        seg_count <= cfg_wdata;
      end
      // issue is low once a query finishes, so this also stops the reads
      rd_valid <= issue;
      if (m_tvalid && m_tready && (state != RESULT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            qx         <= s_tdata[87:72];
            qy         <= s_tdata[103:88];
            res_found  <= 1'b0;
            have_prev  <= 1'b0;
            rd_addr    <= IW'(start_w);
            eval_seg   <= IW'(start_w);
            issue_left <= nq + QW'(1);
            eval_left  <= nq;
            if (is_query && (nq != '0)) begin
              state <= RUN;
            end else begin
              state <= RESULT;
            end
          end
        end
        RUN: begin
          if (issue) begin
            rd_addr    <= rd_addr + IW'(1);
            issue_left <= issue_left - QW'(1);
          end
          if (rd_valid) begin
            prev_e    <= rdata;
            have_prev <= 1'b1;
          end
          if (fin_hit) begin
            res_found <= 1'b1;
            cur_seg   <= eval_seg;
            state     <= RESULT;
          end else if (fin_miss) begin
            state     <= RESULT;
          end else if (res.valid) begin
            eval_seg  <= eval_seg + IW'(1);
            eval_left <= eval_left - QW'(1);
          end
        end
        RESULT: begin
          // Hold until the output register frees up.
          if (out_free) begin
            m_tvalid  <= 1'b1;
            out_found <= res_found;
            out_seg   <= tsl_pkg::IDX_W'(cur_seg);
            state     <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_res_in_run: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (state == RUN))
    else $error("quad result outside of a query");

  a_eval_left: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> (eval_left != '0))
    else $error("query running with no quads left");

  a_cur_seg_range: assert property (@(posedge clk) disable iff (rst)
    (int'(cur_seg) <= MAX_SEGMENTS - 2))
    else $error("current segment past the last quad start");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != IDLE))
    else $error("accepted beat left the block idle");

endmodule
